// File: hdl/dla_pkg.sv
// Shared types and constants for the lease allocator.
// No dependencies.
`default_nettype none
package dla_pkg;
    localparam logic [2:0] KIND_OFFER     = 3'd0;
    localparam logic [2:0] KIND_ACK       = 3'd1;
    localparam logic [2:0] KIND_NAK       = 3'd2;
    localparam logic [2:0] KIND_REJECT    = 3'd3;
    localparam logic [2:0] KIND_EXHAUSTED = 3'd4;

    localparam logic [7:0]  HOST_BYTE_ALL = 8'hFF;
    localparam logic [47:0] MAC_ZERO      = 48'h0;
    localparam logic [47:0] MAC_ONES      = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] REG_SERVER = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;
    localparam logic [1:0] REG_SLOTS  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic        bad_mac;
        logic [47:0] mac;
    } msg_t;

    typedef struct packed {
        logic [31:0] server_addr;
        logic [31:0] pool_start;
        logic [31:0] pool_end;
        logic [4:0]  slots_in_use;
    } cfg_t;
endpackage
`default_nettype wire

// File: hdl/dla_front.sv
// Front end: accepts client messages, flags bad MACs, queues them.
// Depends on dla_pkg.
`default_nettype none
module dla_front import dla_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tuser,
    output logic             q_valid,
    output msg_t             q_msg,
    input  wire logic        q_pop
);
    msg_t       buf_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    msg_t       in_msg;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_msg    = buf_reg[rd_ptr_reg];

    always_comb begin
        in_msg.req_type = s_tuser;
        in_msg.mac      = s_tdata;
        in_msg.bad_mac  = (s_tdata == MAC_ZERO) || (s_tdata == MAC_ONES);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= in_msg;
    end
endmodule
`default_nettype wire

// File: hdl/dla_engine.sv
// Back end: lease table, pool walk and result register.
// Depends on dla_pkg.
`default_nettype none
module dla_engine import dla_pkg::*; #(
    parameter int LEASE_SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    input  wire msg_t        q_msg,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata
);
    localparam int SW = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]  state_reg;
    msg_t        msg_reg;
    logic [LEASE_SLOTS-1:0] slot_valid_reg;
    logic [47:0] slot_mac_reg  [LEASE_SLOTS];
    logic [31:0] slot_addr_reg [LEASE_SLOTS];
    logic        hit_reg, free_ok_reg;
    logic [SW-1:0] hit_idx_reg, free_idx_reg;
    logic [32:0] cand_reg;
    logic [2:0]  res_kind_reg;
    logic [31:0] res_addr_reg;
    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [31:0] out_addr_reg;

    logic [LEASE_SLOTS-1:0] active, mac_hit, addr_hit;
    logic          hit, free_ok, leased, cand_ok, out_free;
    logic [SW-1:0] hit_idx, free_idx;

    always_comb begin
        hit = 1'b0; free_ok = 1'b0;
        hit_idx = '0; free_idx = '0;
        for (int i = LEASE_SLOTS - 1; i >= 0; i--) begin
            active[i]   = (i < 32) && (32'(i) < {27'd0, cfg.slots_in_use});
            mac_hit[i]  = active[i] && slot_valid_reg[i] && (slot_mac_reg[i] == msg_reg.mac);
            addr_hit[i] = active[i] && slot_valid_reg[i]
                          && (slot_addr_reg[i] == cand_reg[31:0]);
            if (mac_hit[i]) begin
                hit = 1'b1; hit_idx = SW'(i);
            end
            if (active[i] && !slot_valid_reg[i]) begin
                free_ok = 1'b1; free_idx = SW'(i);
            end
        end
        leased  = |addr_hit;
        cand_ok = (cand_reg[7:0] != 8'd0) && (cand_reg[7:0] != HOST_BYTE_ALL)
                  && (cand_reg[31:0] != cfg.server_addr) && !leased;
    end

    assign q_pop    = q_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_addr_reg, out_kind_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (state_reg == S_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) state_reg <= S_LOOK;
                end
                S_LOOK: state_reg <= S_DECIDE;
                S_DECIDE: begin
                    if (msg_reg.req_type || msg_reg.bad_mac || hit_reg || !free_ok_reg) begin
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (cand_reg > {1'b0, cfg.pool_end}) begin
                        state_reg <= S_EMIT;
                    end else if (cand_ok) begin
                        slot_valid_reg[free_idx_reg] <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: if (q_valid) msg_reg <= q_msg;
            S_LOOK: begin
                hit_reg      <= hit;
                hit_idx_reg  <= hit_idx;
                free_ok_reg  <= free_ok;
                free_idx_reg <= free_idx;
                cand_reg     <= {1'b0, cfg.pool_start};
            end
            S_DECIDE: begin
                res_addr_reg <= 32'd0;
                if (msg_reg.req_type) begin
                    res_kind_reg <= hit_reg ? KIND_ACK : KIND_NAK;
                    if (hit_reg) res_addr_reg <= slot_addr_reg[hit_idx_reg];
                end else if (msg_reg.bad_mac) begin
                    res_kind_reg <= KIND_REJECT;
                end else if (hit_reg) begin
                    res_kind_reg <= KIND_OFFER;
                    res_addr_reg <= slot_addr_reg[hit_idx_reg];
                end else begin
                    res_kind_reg <= KIND_EXHAUSTED;
                end
            end
            S_WALK: begin
                if (cand_reg > {1'b0, cfg.pool_end}) begin
                    res_kind_reg <= KIND_EXHAUSTED;
                end else if (cand_ok) begin
                    slot_mac_reg[free_idx_reg]  <= msg_reg.mac;
                    slot_addr_reg[free_idx_reg] <= cand_reg[31:0];
                    res_kind_reg <= KIND_OFFER;
                    res_addr_reg <= cand_reg[31:0];
                end else begin
                    cand_reg <= cand_reg + 33'd1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_kind_reg <= res_kind_reg;
                    out_addr_reg <= res_addr_reg;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/dhcp_lease_allocator_unit.sv
// A message passes from the queue through the idle, look, decide and emit states; a
// new lease also walks the pool, passing over addresses it cannot offer.
// Throughput: one message at a time; the engine takes the next one once the
// result is in the output register; the pool walk tests one candidate address per cycle.
// A two-entry queue lets the input side take messages while the walk runs.
// Reset (aresetn, synchronous, low): lease table emptied, queue and
// result cleared, registers back to zero and slot count 16.
`default_nettype none
module dhcp_lease_allocator_unit import dla_pkg::*; #(
    parameter int LEASE_SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // client_mac
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // reply_kind[2:0], client_addr[34:3]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cfg_t cfg_reg;
    logic q_valid, q_pop;
    msg_t q_msg;

    assign pready = 1'b1;

    // Write registers on the access phase; word index sits in paddr[3:2].
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.server_addr  <= 32'd0;
            cfg_reg.pool_start   <= 32'd0;
            cfg_reg.pool_end     <= 32'd0;
            cfg_reg.slots_in_use <= 5'd16;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SERVER: cfg_reg.server_addr  <= pwdata;
                REG_START:  cfg_reg.pool_start   <= pwdata;
                REG_END:    cfg_reg.pool_end     <= pwdata;
                REG_SLOTS:  cfg_reg.slots_in_use <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SERVER: prdata = cfg_reg.server_addr;
            REG_START:  prdata = cfg_reg.pool_start;
            REG_END:    prdata = cfg_reg.pool_end;
            REG_SLOTS:  prdata = {27'd0, cfg_reg.slots_in_use};
            default:    prdata = 32'd0;
        endcase
    end

    // Accept and classify messages, hold them in the queue.
    dla_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid, .q_msg, .q_pop
    );

    // Look up, walk the pool, store the lease, drive the result.
    dla_engine #(.LEASE_SLOTS(LEASE_SLOTS)) u_engine (
        .aclk, .aresetn, .cfg(cfg_reg), .q_valid, .q_msg, .q_pop,
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule
`default_nettype wire
